// File: rtl/core/bounded_deque_with_search_macros.svh
// assertion macros used by the deque datapath
`ifndef BOUNDED_DEQUE_WITH_SEARCH_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_MACROS_SVH
`ifndef NO_ASSERTIONS
// property must hold at every edge outside reset
`define BDQS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bdqs assertion failed");
// condition must never be seen outside reset
`define BDQS_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bdqs forbidden condition seen");
`else
`define BDQS_ASSERT(lbl, clk, rst_n, prop)
`define BDQS_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: rtl/core/bdqs_pkg.sv
// types and codes shared by the deque controller and datapath
package bdqs_pkg;

    localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [2:0] KIND_PUSH_REAR  = 3'd1;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [2:0] KIND_POP_REAR   = 3'd3;
    localparam logic [2:0] KIND_SEARCH     = 3'd4;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] item_value;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_value;
        logic [4:0]         position;
    } t_out_beat;

    typedef enum logic [1:0] {
        VSEL_ECHO,
        VSEL_ZERO,
        VSEL_READ
    } t_val_sel;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP_WAIT,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic       load;
        logic       push;
        logic       pop_read;
        logic       pop_commit;
        logic       scan_first;
        logic       scan_step;
        logic       finish;
        logic [2:0] status;
        t_val_sel   val_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] kind;
        logic       empty;
        logic       full;
        logic       match;
        logic       last;
    } t_dp_status;

endpackage

// File: rtl/core/bdqs_ctrl.sv
// sequencing state machine for the deque
module bdqs_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  bdqs_pkg::t_dp_status i_stat,
    output logic                 busy,
    output bdqs_pkg::t_dp_cmd    o_cmd
);
    import bdqs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                n_state = S_IDLE;
                if ((i_stat.kind == KIND_POP_FRONT || i_stat.kind == KIND_POP_REAR)
                    && !i_stat.empty) begin
                    n_state = S_POP_WAIT;
                end else if (i_stat.kind == KIND_SEARCH && !i_stat.empty) begin
                    n_state = S_SCAN;
                end
            end
            S_POP_WAIT: begin
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (i_stat.match || i_stat.last) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd         = '0;
        o_cmd.status  = ST_DONE;
        o_cmd.val_sel = VSEL_ECHO;
        busy          = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
            end
            S_DISPATCH: begin
                case (i_stat.kind)
                    KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
                        o_cmd.finish = 1'b1;
                        if (i_stat.full) begin
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end
                    KIND_POP_FRONT, KIND_POP_REAR: begin
                        if (i_stat.empty) begin
                            o_cmd.finish  = 1'b1;
                            o_cmd.status  = ST_EMPTY;
                            o_cmd.val_sel = VSEL_ZERO;
                        end else begin
                            o_cmd.pop_read = 1'b1;
                        end
                    end
                    KIND_SEARCH: begin
                        if (i_stat.empty) begin
                            o_cmd.finish = 1'b1;
                            o_cmd.status = ST_EMPTY;
                        end else begin
                            o_cmd.scan_first = 1'b1;
                        end
                    end
                    default: begin
                        o_cmd.finish = 1'b1;
                    end
                endcase
            end
            S_POP_WAIT: begin
                o_cmd.pop_commit = 1'b1;
                o_cmd.finish     = 1'b1;
                o_cmd.val_sel    = VSEL_READ;
            end
            S_SCAN: begin
                if (i_stat.match) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_FOUND;
                end else if (i_stat.last) begin
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_NOT_FOUND;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/core/bdqs_datapath.sv
// ring store, pointers, scan compare and result register for the deque
`include "bounded_deque_with_search_macros.svh"
module bdqs_datapath #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bdqs_pkg::t_in_beat   i_beat,
    input  bdqs_pkg::t_dp_cmd    i_cmd,
    output bdqs_pkg::t_dp_status o_stat,
    output logic                 o_done,
    output bdqs_pkg::t_out_beat  o_result
);
    import bdqs_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [VALUE_WIDTH-1:0] r_mem [DEPTH];
    logic [VALUE_WIDTH-1:0] r_rd_data;
    logic [IW-1:0]          r_front;
    logic [CW-1:0]          r_count;
    logic [2:0]             r_kind;
    logic [31:0]            r_val;
    logic [VALUE_WIDTH-1:0] r_key;
    logic [IW-1:0]          r_off;
    logic [IW-1:0]          r_slot;
    logic                   r_done;
    t_out_beat              r_out;

    logic [IW-1:0]          n_front;
    logic [CW-1:0]          n_count;
    logic [63:0]            key_wide;
    logic [63:0]            rd_wide;
    logic [31:0]            pos_wide;
    logic [CW-1:0]          count_less;
    logic [IW-1:0]          front_dec;
    logic [IW-1:0]          slot_rear;
    logic [IW-1:0]          slot_last;
    logic                   wr_en;
    logic [IW-1:0]          wr_addr;
    logic                   rd_en;
    logic [IW-1:0]          rd_addr;
    logic [31:0]            res_value;

    // ring index step with wrap at DEPTH
    function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] x);
        logic [IW-1:0] y;
        if (x == IW'(DEPTH - 1)) y = '0;
        else                     y = x + IW'(1);
        return y;
    endfunction

    // base plus offset, both below DEPTH, folded back into the ring
    function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                               input logic [IW-1:0] off);
        logic [IW:0] sum;
        sum = (IW+1)'(base) + (IW+1)'(off);
        if (sum >= (IW+1)'(DEPTH)) sum = sum - (IW+1)'(DEPTH);
        return sum[IW-1:0];
    endfunction

    assign key_wide   = {32'd0, i_beat.item_value};
    assign rd_wide    = 64'(r_rd_data);
    assign pos_wide   = 32'(r_off) + 32'd1;
    assign count_less = r_count - CW'(1);
    assign front_dec  = (r_front == '0) ? IW'(DEPTH - 1) : r_front - IW'(1);
    assign slot_rear  = ring_add(r_front, r_count[IW-1:0]);
    assign slot_last  = ring_add(r_front, count_less[IW-1:0]);

    always_comb begin
        wr_en   = i_cmd.push;
        wr_addr = (r_kind == KIND_PUSH_FRONT) ? front_dec : slot_rear;
        rd_en   = i_cmd.pop_read | i_cmd.scan_first | i_cmd.scan_step;
        if (i_cmd.pop_read) begin
            rd_addr = (r_kind == KIND_POP_FRONT) ? r_front : slot_last;
        end else if (i_cmd.scan_first) begin
            rd_addr = r_front;
        end else begin
            rd_addr = r_slot;
        end
    end

    always_comb begin
        n_front = r_front;
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + CW'(1);
            if (r_kind == KIND_PUSH_FRONT) n_front = front_dec;
        end else if (i_cmd.pop_commit) begin
            n_count = count_less;
            if (r_kind == KIND_POP_FRONT) n_front = ring_inc(r_front);
        end
    end

    always_comb begin
        case (i_cmd.val_sel)
            VSEL_ZERO: res_value = '0;
            VSEL_READ: res_value = rd_wide[31:0];
            default:   res_value = r_val;
        endcase
    end

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= r_key;
        if (rd_en) r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            r_done  <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_beat.kind;
            r_val  <= i_beat.item_value;
            r_key  <= key_wide[VALUE_WIDTH-1:0];
        end
        if (i_cmd.scan_first) begin
            r_off  <= '0;
            r_slot <= ring_inc(r_front);
        end else if (i_cmd.scan_step) begin
            r_off  <= r_off + IW'(1);
            r_slot <= ring_inc(r_slot);
        end
        if (i_cmd.finish) begin
            r_out.status    <= i_cmd.status;
            r_out.out_value <= res_value;
            r_out.position  <= (i_cmd.status == ST_FOUND) ? pos_wide[4:0] : 5'd0;
        end
    end

    assign o_stat.kind  = r_kind;
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.match = (r_rd_data == r_key);
    assign o_stat.last  = ((CW'(r_off) + CW'(1)) == r_count);
    assign o_done       = r_done;
    assign o_result     = r_out;

    `BDQS_NEVER(a_no_push_when_full, i_clk, i_rst_n, i_cmd.push && o_stat.full)
    `BDQS_ASSERT(a_commit_after_read, i_clk, i_rst_n, i_cmd.pop_commit |-> $past(i_cmd.pop_read))
    `BDQS_ASSERT(a_push_grows, i_clk, i_rst_n, i_cmd.push |=> r_count == $past(r_count) + CW'(1))
    `BDQS_NEVER(a_count_in_range, i_clk, i_rst_n, r_count > CW'(DEPTH))

endmodule

// File: rtl/core/bounded_deque_with_search.sv
// deque with front and rear push/pop and a linear search, top level
// the result strobe is registered from finish, raised by dispatch for a push, an
// unknown kind or a full or empty case, by pop read wait for a pop and by the scan
// loop for a search; a new beat is taken only once idle, in the cycle the strobe
// shows; the search walks the ring one entry per cycle on one read port
// synchronous active-low reset empties the deque; the store itself is not cleared
module bounded_deque_with_search #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  bdqs_pkg::t_in_beat  i_beat,
    output logic                busy,
    output logic                o_done,
    output bdqs_pkg::t_out_beat o_result
);
    import bdqs_pkg::*;

    // command beat from the controller, status back from the datapath
    t_dp_cmd    dp_cmd;
    t_dp_status dp_stat;

    // controller: idle, dispatch, pop read wait, scan loop
    bdqs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (dp_stat),
        .busy    (busy),
        .o_cmd   (dp_cmd)
    );

    // datapath: ring store, front pointer, fill count, result register
    bdqs_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (i_beat),
        .i_cmd    (dp_cmd),
        .o_stat   (dp_stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
